@@ src/hr_pkg.sv @@
// ----------------------------------------------------------------------------
// hr_pkg
// Shared widths, register codes, controller states and command/status types
// of the histogram rebinner.
// ----------------------------------------------------------------------------
`default_nettype none

package hr_pkg;

   localparam int MAX_BIN_SIZE = 256;
   localparam int MAX_BINS     = 65536;

   localparam int POS_W   = 32;
   localparam int COUNT_W = 32;
   localparam int VALUE_W = 40;
   localparam int SUM_W   = 40;
   localparam int SIZE_W  = 9;
   localparam int FRAC_W  = 16;

   localparam int FILL_W  = $clog2(MAX_BIN_SIZE + 1);
   localparam int INDEX_W = $clog2(MAX_BINS);

   // bin index shown as position: integer part of a signed q16.16
   localparam int IDX_POS_W   = POS_W - FRAC_W - 1;
   localparam int IDX_POS_MAX = (2 ** IDX_POS_W) - 1;

   localparam int DIV_BITS_PER_STEP = 4;
   localparam int DIV_STEPS         = SUM_W / DIV_BITS_PER_STEP;
   localparam int STEP_W            = $clog2(DIV_STEPS);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BIN_SIZE        = 2'd0,
      CSR_NORMALIZE       = 2'd1,
      CSR_INDEX_POSITIONS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_ACCEPT,
      ST_DIVIDE,
      ST_DELIVER
   } hr_state_type;

   typedef struct packed {
      logic take;
      logic div_step;
      logic load_out;
   } hr_cmd_type;

   typedef struct packed {
      logic closes;
   } hr_sts_type;

endpackage

`default_nettype wire

@@ src/hr_req_if.sv @@
// ----------------------------------------------------------------------------
// hr_req_if
// Channel word stream: one histogram channel per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hr_req_if import hr_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] channel_position;
   logic [COUNT_W-1:0]      count_value;
   logic                    last_channel;

   modport source (output valid, output channel_position, output count_value,
                   output last_channel, input ready);
   modport sink   (input valid, input channel_position, input count_value,
                   input last_channel, output ready);
endinterface

`default_nettype wire

@@ src/hr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// hr_rsp_if
// Bin word stream: one rebinned bin per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hr_rsp_if import hr_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] bin_position;
   logic [VALUE_W-1:0]      bin_value;
   logic                    last_bin;

   modport source (output valid, output bin_position, output bin_value,
                   output last_bin, input ready);
   modport sink   (input valid, input bin_position, input bin_value,
                   input last_bin, output ready);
endinterface

`default_nettype wire

@@ src/hr_csr_if.sv @@
// ----------------------------------------------------------------------------
// hr_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface hr_csr_if import hr_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/hr_ctrl.sv @@
// ----------------------------------------------------------------------------
// hr_ctrl
// Sequencer: accepts channel words, runs the divider for a closing bin and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hr_ctrl import hr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  hr_sts_type sts,
   output hr_cmd_type cmd
);

   hr_state_type       state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_ACCEPT: begin
            step_in = '0;
            if (req_valid && sts.closes) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               state_in = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_ACCEPT: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_DELIVER: begin
            cmd.load_out = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ src/hr_datapath.sv @@
// ----------------------------------------------------------------------------
// hr_datapath
// Configuration registers, bin accumulators, a pair of radix-16 dividers for
// the mean position and mean count, and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module hr_datapath import hr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   input  logic signed [POS_W-1:0] channel_position,
   input  logic [COUNT_W-1:0]      count_value,
   input  logic                    last_channel,
   input  hr_cmd_type              cmd,
   output hr_sts_type              sts,
   output logic signed [POS_W-1:0] bin_position,
   output logic [VALUE_W-1:0]      bin_value,
   output logic                    last_bin
);

   typedef struct packed {
      logic [FILL_W-1:0] rem;
      logic [SUM_W-1:0]  dq;
   } div_state_type;

   // restoring division, several quotient bits per call
   function automatic div_state_type div_iter(div_state_type s, logic [FILL_W-1:0] d);
      div_state_type   r;
      logic [FILL_W:0] trial;
      r = s;
      for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
         trial = {r.rem, r.dq[SUM_W-1]};
         r.dq  = {r.dq[SUM_W-2:0], 1'b0};
         if (trial >= {1'b0, d}) begin
            r.rem   = FILL_W'(trial - {1'b0, d});
            r.dq[0] = 1'b1;
         end else begin
            r.rem = trial[FILL_W-1:0];
         end
      end
      return r;
   endfunction

   // configuration
   logic [SIZE_W-1:0]  bin_size_ff;
   logic               normalize_ff;
   logic               index_positions_ff;

   // open bin
   logic [SUM_W-1:0]   pos_sum_ff, pos_sum_in;
   logic [SUM_W-1:0]   cnt_sum_ff, cnt_sum_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [INDEX_W-1:0] bin_index_ff, bin_index_in;

   // divider
   div_state_type      pos_div_ff, pos_div_in;
   div_state_type      cnt_div_ff, cnt_div_in;
   logic [FILL_W-1:0]  pos_dvs_ff, pos_dvs_in;
   logic [FILL_W-1:0]  cnt_dvs_ff, cnt_dvs_in;
   logic               pos_neg_ff, pos_neg_in;
   logic               last_ff, last_in;
   logic [IDX_POS_W-1:0] idx_ff, idx_in;

   // output word
   logic [POS_W-1:0]   bin_position_ff, bin_position_in;
   logic [VALUE_W-1:0] bin_value_ff, bin_value_in;
   logic               last_bin_ff, last_bin_in;

   logic [FILL_W-1:0]  eff_size;
   logic [SUM_W-1:0]   pos_ext;
   logic [SUM_W-1:0]   pos_sum_next;
   logic [SUM_W:0]     cnt_wide;
   logic [SUM_W-1:0]   cnt_sum_next;
   logic [FILL_W-1:0]  fill_next;
   logic [SUM_W-1:0]   mean_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_size_ff        <= SIZE_W'(1);
         normalize_ff       <= 1'b0;
         index_positions_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_BIN_SIZE:        bin_size_ff        <= SIZE_W'(csr_data);
            CSR_NORMALIZE:       normalize_ff       <= csr_data[0];
            CSR_INDEX_POSITIONS: index_positions_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // zero acts as one, oversize saturates
   always_comb begin
      if (bin_size_ff == '0) begin
         eff_size = FILL_W'(1);
      end else if (32'(bin_size_ff) > 32'(MAX_BIN_SIZE)) begin
         eff_size = FILL_W'(MAX_BIN_SIZE);
      end else begin
         eff_size = FILL_W'(bin_size_ff);
      end
   end

   assign pos_ext      = {{(SUM_W-POS_W){channel_position[POS_W-1]}}, channel_position};
   assign pos_sum_next = pos_sum_ff + pos_ext;
   assign cnt_wide     = {1'b0, cnt_sum_ff} + (SUM_W+1)'(count_value);
   assign cnt_sum_next = cnt_wide[SUM_W] ? '1 : cnt_wide[SUM_W-1:0];
   assign fill_next    = (32'(fill_ff) < 32'(MAX_BIN_SIZE)) ? fill_ff + 1'b1 : fill_ff;
   assign sts.closes   = (fill_next >= eff_size) || last_channel;

   always_comb begin
      pos_sum_in   = pos_sum_ff;
      cnt_sum_in   = cnt_sum_ff;
      fill_in      = fill_ff;
      bin_index_in = bin_index_ff;
      pos_div_in   = pos_div_ff;
      cnt_div_in   = cnt_div_ff;
      pos_dvs_in   = pos_dvs_ff;
      cnt_dvs_in   = cnt_dvs_ff;
      pos_neg_in   = pos_neg_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      if (cmd.take) begin
         if (sts.closes) begin
            pos_sum_in     = '0;
            cnt_sum_in     = '0;
            fill_in        = '0;
            pos_neg_in     = pos_sum_next[SUM_W-1];
            pos_div_in.rem = '0;
            pos_div_in.dq  = pos_sum_next[SUM_W-1] ? (~pos_sum_next + 1'b1) : pos_sum_next;
            cnt_div_in.rem = '0;
            cnt_div_in.dq  = cnt_sum_next;
            pos_dvs_in     = fill_next;
            // divide by one when the count passes through unchanged
            cnt_dvs_in     = normalize_ff ? fill_next : FILL_W'(1);
            last_in        = last_channel;
            idx_in         = (32'(bin_index_ff) > 32'(IDX_POS_MAX)) ?
                             IDX_POS_W'(IDX_POS_MAX) : IDX_POS_W'(bin_index_ff);
            if (last_channel) begin
               bin_index_in = '0;
            end else if (32'(bin_index_ff) < 32'(MAX_BINS - 1)) begin
               bin_index_in = bin_index_ff + 1'b1;
            end
         end else begin
            pos_sum_in = pos_sum_next;
            cnt_sum_in = cnt_sum_next;
            fill_in    = fill_next;
         end
      end else if (cmd.div_step) begin
         pos_div_in = div_iter(pos_div_ff, pos_dvs_ff);
         cnt_div_in = div_iter(cnt_div_ff, cnt_dvs_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_sum_ff   <= '0;
         cnt_sum_ff   <= '0;
         fill_ff      <= '0;
         bin_index_ff <= '0;
      end else begin
         pos_sum_ff   <= pos_sum_in;
         cnt_sum_ff   <= cnt_sum_in;
         fill_ff      <= fill_in;
         bin_index_ff <= bin_index_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_div_ff <= pos_div_in;
      cnt_div_ff <= cnt_div_in;
      pos_dvs_ff <= pos_dvs_in;
      cnt_dvs_ff <= cnt_dvs_in;
      pos_neg_ff <= pos_neg_in;
      last_ff    <= last_in;
      idx_ff     <= idx_in;
   end

   // quotient magnitude back to signed, truncated toward zero
   assign mean_full = pos_neg_ff ? (~pos_div_ff.dq + 1'b1) : pos_div_ff.dq;

   always_comb begin
      bin_position_in = bin_position_ff;
      bin_value_in    = bin_value_ff;
      last_bin_in     = last_bin_ff;
      if (cmd.load_out) begin
         if (index_positions_ff) begin
            bin_position_in = POS_W'({idx_ff, {FRAC_W{1'b0}}});
         end else begin
            bin_position_in = mean_full[POS_W-1:0];
         end
         bin_value_in = VALUE_W'(cnt_div_ff.dq);
         last_bin_in  = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      bin_position_ff <= bin_position_in;
      bin_value_ff    <= bin_value_in;
      last_bin_ff     <= last_bin_in;
   end

   assign bin_position = bin_position_ff;
   assign bin_value    = bin_value_ff;
   assign last_bin     = last_bin_ff;

endmodule

`default_nettype wire

@@ src/histogram_rebinner_core.sv @@
// ----------------------------------------------------------------------------
// histogram_rebinner_core
// Merges consecutive histogram channels into wider bins and gives one bin
// word per closed bin: mean position or bin index, and summed or mean count.
//
//   channel   dir  handshake     payload
//   req_ch    in   valid/ready   channel_position, count_value, last_channel
//   rsp_ch    out  valid/ready   bin_position, bin_value, last_bin
//   csr_ch    in   valid/ready   index, data (ready always high)
//
// a channel that leaves its bin open is only added to the open bin
// a channel that closes a bin goes through accept, 10 steps of the
// position/count divider pair (4 quotient bits a cycle), and the output load
// the output register holds a bin word while further channels are accepted;
// a closing channel waits at the load until the previous word is taken
// synchronous reset: bin_size 1, normalize and index_positions off, empty bin
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_rebinner_core import hr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   hr_req_if.sink    req_ch,
   hr_rsp_if.source  rsp_ch,
   hr_csr_if.sink    csr_ch
);

   hr_cmd_type cmd;
   hr_sts_type sts;

   assign csr_ch.ready = 1'b1;

   hr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_ch.valid && csr_ch.ready),
      .csr_index        (csr_ch.index),
      .csr_data         (csr_ch.data),
      .channel_position (req_ch.channel_position),
      .count_value      (req_ch.count_value),
      .last_channel     (req_ch.last_channel),
      .cmd              (cmd),
      .sts              (sts),
      .bin_position     (rsp_ch.bin_position),
      .bin_value        (rsp_ch.bin_value),
      .last_bin         (rsp_ch.last_bin)
   );

endmodule

`default_nettype wire

@@ src/hr_checker.sv @@
// ----------------------------------------------------------------------------
// hr_checker
// Port-level checks of the histogram rebinner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hr_checker import hr_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_last_channel,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [POS_W-1:0]   rsp_bin_position,
   input logic [VALUE_W-1:0] rsp_bin_value
);

   // a stalled bin word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_bin_value) && $stable(rsp_bin_position))
      else $error("bin word changed while stalled");

   // no bin word right after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("bin word valid out of reset");

   // a last channel always closes a bin and stalls the input for the divide
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_channel |=> !req_ready)
      else $error("last channel did not close a bin");

   // a new bin word is loaded only while the input is held off
   a_load_stalls: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("bin word appeared while input was open");

endmodule

bind histogram_rebinner_core hr_checker u_hr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_last_channel (req_ch.last_channel),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_bin_position (rsp_ch.bin_position),
   .rsp_bin_value    (rsp_ch.bin_value)
);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for histogram_rebinner_core. Channel words go out from
// a pending queue in bursts with random gaps, and bin words are taken under a
// shifting stall pattern. Each accepted channel is folded into a local
// rebinning model, and every closed bin is compared field by field with the
// oldest expected bin word. Register settings change between phases: small,
// odd, zero and oversized bin sizes, both value and position modes, open bins
// carried across a size change, and one steady run in index mode.
// ----------------------------------------------------------------------------

module tb_top;
   import hr_pkg::*;

   localparam int SETTLE_CYCLES = 24;
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int INDEX_RUN     = 200;
   localparam int PRINT_LIMIT   = 40;
   localparam int INDEX_CAP     = 32767;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic [COUNT_W-1:0]      count;
      logic                    last;
   } chan_word_type;

   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic [VALUE_W-1:0]      value;
      logic                    last;
   } bin_word_type;

   logic clock = 1'b0;
   logic reset;

   hr_req_if req_if ();
   hr_rsp_if rsp_if ();
   hr_csr_if csr_if ();

   histogram_rebinner_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   chan_word_type channels_pending[$];
   bin_word_type  bins_expected[$];
   int unsigned mismatch_count = 0;
   bit steady = 1'b0;

   // model copy of registers and the open bin
   logic [SIZE_W-1:0]      cfg_bin_size;
   logic                   cfg_normalize;
   logic                   cfg_index_positions;
   logic signed [SUM_W-1:0] acc_position;
   logic [SUM_W-1:0]       acc_count;
   int unsigned            acc_fill;
   int unsigned            open_bin;

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic fold_channel(input chan_word_type w);
      int unsigned bin_len;
      logic [SUM_W:0] wide_count;
      longint merged;
      longint mean;
      int unsigned idx;
      bin_word_type b;
      bin_len = (cfg_bin_size == 0) ? 1 :
                (32'(cfg_bin_size) > MAX_BIN_SIZE) ? MAX_BIN_SIZE : 32'(cfg_bin_size);
      acc_position = acc_position + {{(SUM_W-POS_W){w.position[POS_W-1]}}, w.position};
      wide_count = {1'b0, acc_count} + (SUM_W+1)'(w.count);
      acc_count = wide_count[SUM_W] ? '1 : wide_count[SUM_W-1:0];
      if (acc_fill < MAX_BIN_SIZE) acc_fill++;
      if (acc_fill >= bin_len || w.last) begin
         if (cfg_index_positions) begin
            idx = (open_bin > INDEX_CAP) ? INDEX_CAP : open_bin;
            b.position = POS_W'(idx << FRAC_W);
         end else begin
            merged = longint'(acc_position);
            mean = merged / longint'(acc_fill);
            b.position = mean[POS_W-1:0];
         end
         b.value = cfg_normalize ? acc_count / SUM_W'(acc_fill) : acc_count;
         b.last = w.last;
         bins_expected.push_back(b);
         acc_position = '0;
         acc_count = '0;
         acc_fill = 0;
         if (w.last) open_bin = 0;
         else if (open_bin < MAX_BINS - 1) open_bin++;
      end
   endtask

   // monitor: checks bin words, folds channels, tracks register writes
   int unsigned idle_cycles = 0;
   bin_word_type want;

   always @(posedge clock) begin
      if (reset) begin
         cfg_bin_size = 1;
         cfg_normalize = 1'b0;
         cfg_index_positions = 1'b0;
         acc_position = '0;
         acc_count = '0;
         acc_fill = 0;
         open_bin = 0;
      end else begin
         // check before folding: a word taken now cannot come from this channel
         if (rsp_if.valid && rsp_if.ready) begin
            if (bins_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected bin word pos=%h value=%h last=%b",
                  rsp_if.bin_position, rsp_if.bin_value, rsp_if.last_bin));
            end else begin
               want = bins_expected.pop_front();
               if (rsp_if.bin_position !== want.position)
                  report_mismatch($sformatf("bin_position got %h want %h",
                     rsp_if.bin_position, want.position));
               if (rsp_if.bin_value !== want.value)
                  report_mismatch($sformatf("bin_value got %h want %h",
                     rsp_if.bin_value, want.value));
               if (rsp_if.last_bin !== want.last)
                  report_mismatch($sformatf("last_bin got %b want %b",
                     rsp_if.last_bin, want.last));
            end
         end
         if (req_if.valid && req_if.ready)
            fold_channel('{req_if.channel_position, req_if.count_value,
                           req_if.last_channel});
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_BIN_SIZE:        cfg_bin_size = csr_if.data;
               CSR_NORMALIZE:       cfg_normalize = csr_if.data[0];
               CSR_INDEX_POSITIONS: cfg_index_positions = csr_if.data[0];
               default: ;
            endcase
         end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // channel driver: bursts of random length separated by random gaps
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   chan_word_type next_chan;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.channel_position <= '0;
         req_if.count_value <= '0;
         req_if.last_channel <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left != 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (channels_pending.size() != 0) begin
            next_chan = channels_pending.pop_front();
            req_if.channel_position <= next_chan.position;
            req_if.count_value <= next_chan.count;
            req_if.last_channel <= next_chan.last;
            req_if.valid <= 1'b1;
            if (burst_left != 0) burst_left--;
            if (burst_left == 0 && !steady) begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // bin word receiver: stall rate is redrawn from four settings at the end of each mode
   int unsigned ready_hold = 0;
   int unsigned mode_left = 0;
   int unsigned stall_pct = 0;
   logic ready_level = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         ready_hold = 0;
         mode_left = 0;
         ready_level = 1'b1;
      end else begin
         if (mode_left == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 15;
               2: stall_pct = 40;
               default: stall_pct = 80;
            endcase
            mode_left = 300;
         end else begin
            mode_left--;
         end
         if (ready_hold != 0) begin
            ready_hold--;
         end else if (steady) begin
            ready_level = 1'b1;
         end else if (ready_level && $urandom_range(0, 99) < stall_pct) begin
            ready_level = 1'b0;
            ready_hold = $urandom_range(0, 23);
         end else begin
            ready_level = 1'b1;
            ready_hold = $urandom_range(0, 5);
         end
         rsp_if.ready <= ready_level;
      end
   end

   function automatic logic [POS_W-1:0] pick_position();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 32'h0010_0000);
         3: return 32'd0 - $urandom_range(1, 32'h0010_0000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(0, 7))
         0: return 32'hFFFF_FFFF;
         1: return 32'd0;
         2: return $urandom_range(0, 1000);
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_channel(input logic [POS_W-1:0] pos,
                                input logic [COUNT_W-1:0] cnt, input logic last);
      chan_word_type w;
      w.position = pos;
      w.count = cnt;
      w.last = last;
      channels_pending.push_back(w);
   endtask

   // called right after a rising edge; the caller lowers valid
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
   endtask

   // upper data bits of the flag registers are random and must be ignored
   task automatic set_config(input logic [SIZE_W-1:0] bin_len, input logic norm,
                             input logic idx_pos);
      @(posedge clock);
      csr_write(CSR_BIN_SIZE, bin_len);
      csr_write(CSR_NORMALIZE, {8'($urandom()), norm});
      csr_write(CSR_INDEX_POSITIONS, {8'($urandom()), idx_pos});
      csr_if.valid <= 1'b0;
   endtask

   // sampled at the falling edge so the driver and monitor have settled
   task automatic wait_idle();
      do @(negedge clock);
      while (channels_pending.size() != 0 || req_if.valid || bins_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int unsigned random_sent;
      int unsigned phase;
      int unsigned bin_len;
      int unsigned eff;
      int unsigned hist_count;
      int unsigned len;
      bit large_phase;
      bit leave_open;
      bit noisy;
      logic last;

      reset <= 1'b1;
      csr_if.valid <= 1'b0;
      csr_if.index <= CSR_BIN_SIZE;
      csr_if.data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one channel per bin, field extremes
      queue_channel(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      queue_channel(32'h8000_0000, 32'd0, 1'b0);
      queue_channel(32'hFFFF_FFFF, 32'd1, 1'b1);
      wait_idle();

      // negative mean truncates toward zero; normalized full and short bins
      set_config(4, 1'b1, 1'b0);
      @(posedge clock);
      csr_write(CSR_SPARE_INDEX, 9'h1FF);
      csr_if.valid <= 1'b0;
      queue_channel(32'hFFFF_FFFD, 32'hFFFF_FFFF, 1'b0);
      queue_channel(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
      queue_channel(32'd0, 32'd1, 1'b0);
      queue_channel(32'd0, 32'd0, 1'b0);
      queue_channel(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      queue_channel(32'h7FFF_FFFF, 32'd6, 1'b1);
      wait_idle();

      // shrink the size under an open bin, then a zero size
      set_config(3, 1'b0, 1'b1);
      queue_channel(32'h0001_0000, 32'd10, 1'b0);
      queue_channel(32'h0002_0000, 32'd20, 1'b0);
      wait_idle();
      set_config(2, 1'b0, 1'b1);
      queue_channel(32'h0003_0000, 32'd30, 1'b0);
      queue_channel(32'h8000_0000, 32'd5, 1'b0);
      wait_idle();
      set_config(0, 1'b1, 1'b0);
      queue_channel(32'h8000_0001, 32'd7, 1'b0);
      queue_channel(32'h1234_5678, 32'hFFFF_FFFE, 1'b1);
      wait_idle();

      // random histograms; every sixth phase uses an oversized or wide bin
      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         large_phase = (phase % 6 == 5);
         if (large_phase) begin
            case ((phase / 6) % 4)
               0: bin_len = 256;
               1: bin_len = 511;
               2: bin_len = 300;
               default: bin_len = 257;
            endcase
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: bin_len = $urandom_range(1, 8);
               6, 7: bin_len = $urandom_range(9, 40);
               8: bin_len = 0;
               default: bin_len = $urandom_range(1, 3);
            endcase
         end
         set_config(SIZE_W'(bin_len), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
         eff = (bin_len == 0) ? 1 : (bin_len > MAX_BIN_SIZE) ? MAX_BIN_SIZE : bin_len;
         hist_count = large_phase ? 1 : $urandom_range(1, 4);
         for (int h = 0; h < hist_count; h++) begin
            len = eff * $urandom_range(0, large_phase ? 1 : 5) + $urandom_range(0, eff - 1);
            if (len == 0) len = eff;
            // an unterminated tail carries an open bin into the next setting
            leave_open = (h == hist_count - 1) && ($urandom_range(0, 4) == 0);
            noisy = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++) begin
               last = ((i == len - 1) && !leave_open) ||
                      (noisy && $urandom_range(0, 9) == 0);
               queue_channel(pick_position(), pick_count(), last);
            end
            random_sent += len;
         end
         wait_idle();
         phase++;
      end

      // one histogram of single-channel bins in index mode, no idling
      set_config(1, 1'($urandom_range(0, 1)), 1'b1);
      steady = 1'b1;
      for (int i = 0; i < INDEX_RUN; i++)
         queue_channel(pick_position(), pick_count(), i == INDEX_RUN - 1);
      wait_idle();
      steady = 1'b0;

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ histogram_rebinner_core.f @@
src/hr_pkg.sv
src/hr_req_if.sv
src/hr_rsp_if.sv
src/hr_csr_if.sv
src/hr_ctrl.sv
src/hr_datapath.sv
src/histogram_rebinner_core.sv
src/hr_checker.sv
tb/sv/tb_top.sv
